/* hdl/fthr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fthr_pkg: shared definitions for the force threshold reporter
// widths, register indexes, mode codes and the divider status bundle
// ----------------------------------------------------------------------------
package fthr_pkg;

    // default parameter values
    localparam int RAW_BITS_DEF  = 16;
    localparam int TIME_BITS_DEF = 32;

    // fixed field widths
    localparam int LIM_W     = 16;   // lower and upper limits
    localparam int PCT_W     = 7;    // percent values
    localparam int MODE_W    = 2;    // error and lock modes
    localparam int DELAY_W   = 26;   // off delay in ms
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = DELAY_W;
    localparam int RAW_VAL_W = 16;   // reported raw value
    localparam int NUM_W     = LIM_W + PCT_W;  // 100 * (raw - lower)
    localparam int QSTEPS    = PCT_W;          // quotient never exceeds 100
    localparam int QCNT_W    = 3;

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOWER     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DETECT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HYST      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ERR_MODE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LOCK_MODE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_DELAY = 3'd7;

    // error modes
    localparam logic [MODE_W-1:0] ERR_OFF   = 2'd0;
    localparam logic [MODE_W-1:0] ERR_ON    = 2'd1;
    localparam logic [MODE_W-1:0] ERR_SPLIT = 2'd2;
    localparam logic [MODE_W-1:0] ERR_KEEP  = 2'd3;

    // lock modes
    localparam logic [MODE_W-1:0] LOCK_KEEP = 2'd0;
    localparam logic [MODE_W-1:0] LOCK_OFF  = 2'd1;
    localparam logic [MODE_W-1:0] LOCK_ON   = 2'd2;

    // divider status towards the sequencer
    typedef struct packed {
        logic             done;
        logic [PCT_W-1:0] quot;
    } div_stat_t;

endpackage

/* hdl/fthr_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fthr_div: restoring divider for the percent
// one shared compare and subtract per cycle, one quotient bit per step
// ----------------------------------------------------------------------------
module fthr_div
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [fthr_pkg::NUM_W-1:0]     numer,
    input  logic [fthr_pkg::LIM_W-1:0]     denom,
    output fthr_pkg::div_stat_t            stat
);

    logic [fthr_pkg::NUM_W-1:0]  rem_reg, rem_next;
    logic [fthr_pkg::NUM_W-1:0]  dsh_reg, dsh_next;
    logic [fthr_pkg::PCT_W-1:0]  quot_reg, quot_next;
    logic [fthr_pkg::QCNT_W-1:0] step_reg, step_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic                        fits;
    logic [fthr_pkg::NUM_W-1:0]  diff;

    // shared compare and subtract
    assign fits = (rem_reg >= dsh_reg);
    assign diff = rem_reg - dsh_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quot_next = quot_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = numer;
            dsh_next  = fthr_pkg::NUM_W'(denom) << (fthr_pkg::QSTEPS - 1);
            quot_next = '0;
            step_next = fthr_pkg::QCNT_W'(fthr_pkg::QSTEPS - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = diff;
            end
            quot_next = {quot_reg[fthr_pkg::PCT_W-2:0], fits};
            dsh_next  = dsh_reg >> 1;
            step_next = step_reg - 1'b1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quot_reg <= quot_next;
    end

    assign stat.done = done_reg;
    assign stat.quot = quot_reg;

endmodule

/* hdl/force_threshold_hysteresis_reporter_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// force_threshold_hysteresis_reporter_unit: force threshold detector
// percent scaling, hysteresis detection, error and lock modes, change-based
// reports and a delayed-off switch
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake              | contents
//  ---------+-----------+------------------------+------------------------------
//  s_*      | in        | s_tvalid / s_tready    | raw sample, time, lock/diag/force
//  m_*      | out       | m_tvalid / m_tready    | five report flags and values
//  cfg_*    | in        | cfg_wr_en, no wait     | eight limit and mode registers
//
//  after its input transaction is accepted, a result passes one divider load,
//  seven restoring steps through the shared compare and subtract, the divider
//  done flag and the result load; the next transaction is taken only once the
//  sequencer is back in idle after the result load, even if the sink has not
//  yet taken the result; a stalled sink holds the sequencer in its result state
//  while the previous result still waits; reset loads the register defaults and
//  clears all history
//
module force_threshold_hysteresis_reporter_unit
#(
    parameter int RAW_BITS  = fthr_pkg::RAW_BITS_DEF,
    parameter int TIME_BITS = fthr_pkg::TIME_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration write port
    input  logic                                  cfg_wr_en,
    input  logic [fthr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [fthr_pkg::CFG_W-1:0]            cfg_data,
    // input stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // raw_sample, time_ms, lock_on, diag_on, force_report, zero fill
    input  logic [((RAW_BITS+TIME_BITS+3+7)/8)*8-1:0] s_tdata,
    // result stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // raw_report, raw_value, percent_report, percent_value, error_report,
    // error_flag, detect_report, detect_flag, delayed_report, delayed_flag,
    // zero fill
    output logic [31:0]                           m_tdata
);

    localparam int RAW_CMP_W = (RAW_BITS > fthr_pkg::LIM_W) ? RAW_BITS : fthr_pkg::LIM_W;
    localparam int DLY_CMP_W = (TIME_BITS > fthr_pkg::DELAY_W) ? TIME_BITS
                                                              : fthr_pkg::DELAY_W;
    localparam int OUT_USED  = 8 + fthr_pkg::RAW_VAL_W + fthr_pkg::PCT_W;
    localparam int OUT_W     = 32;

    typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_DIV, ST_FIN} state_t;

    // configuration registers
    logic [fthr_pkg::LIM_W-1:0]   lower_reg, upper_reg;
    logic [fthr_pkg::PCT_W-1:0]   detect_pct_reg, hyst_reg, step_cfg_reg;
    logic [fthr_pkg::MODE_W-1:0]  err_mode_reg, lock_mode_reg;
    logic [fthr_pkg::DELAY_W-1:0] off_delay_reg;

    // captured transaction
    logic [RAW_BITS-1:0]  raw_reg;
    logic [TIME_BITS-1:0] time_reg;
    logic                 lock_reg, diag_reg, force_reg;

    // history
    logic [RAW_BITS-1:0]        prev_raw_reg, prev_raw_next;
    logic [fthr_pkg::PCT_W-1:0] prev_pct_reg, prev_pct_next;
    logic                       prev_err_reg, prev_err_next;
    logic                       prev_det_reg, prev_det_next;
    logic [TIME_BITS-1:0]       chg_time_reg, chg_time_next;
    logic                       prev_dly_reg, prev_dly_next;

    state_t                     state_reg, state_next;
    logic                       out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]           out_data_reg, out_data_next;

    fthr_pkg::div_stat_t        div_stat;
    logic                       div_start;
    logic [fthr_pkg::NUM_W-1:0] numer;
    logic [fthr_pkg::LIM_W-1:0] span;
    logic [fthr_pkg::LIM_W-1:0] offset;

    // classification and result terms
    logic [RAW_CMP_W-1:0]       raw_ext;
    logic                       under, over, err;
    logic [fthr_pkg::PCT_W-1:0] pct, limit, step, pct_diff;
    logic                       det, det_base;
    logic [RAW_BITS-1:0]        raw_out;
    logic                       raw_rep, pct_rep, err_rep, det_rep, dly_chg, dly_rep, sw;
    logic [TIME_BITS-1:0]       elapsed;
    logic                       load_out;

    // ------------------------------------------------------------------------
    // configuration writes
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg      <= 16'd1;
            upper_reg      <= 16'd1023;
            detect_pct_reg <= 7'd50;
            hyst_reg       <= '0;
            step_cfg_reg   <= 7'd1;
            err_mode_reg   <= fthr_pkg::ERR_OFF;
            lock_mode_reg  <= fthr_pkg::LOCK_KEEP;
            off_delay_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                fthr_pkg::REG_LOWER:     lower_reg      <= cfg_data[fthr_pkg::LIM_W-1:0];
                fthr_pkg::REG_UPPER:     upper_reg      <= cfg_data[fthr_pkg::LIM_W-1:0];
                fthr_pkg::REG_DETECT:    detect_pct_reg <= cfg_data[fthr_pkg::PCT_W-1:0];
                fthr_pkg::REG_HYST:      hyst_reg       <= cfg_data[fthr_pkg::PCT_W-1:0];
                fthr_pkg::REG_STEP:      step_cfg_reg   <= cfg_data[fthr_pkg::PCT_W-1:0];
                fthr_pkg::REG_ERR_MODE:  err_mode_reg   <= cfg_data[fthr_pkg::MODE_W-1:0];
                fthr_pkg::REG_LOCK_MODE: lock_mode_reg  <= cfg_data[fthr_pkg::MODE_W-1:0];
                fthr_pkg::REG_OFF_DELAY: off_delay_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // input capture, one transaction at a time
    // ------------------------------------------------------------------------
    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            raw_reg   <= s_tdata[RAW_BITS-1:0];
            time_reg  <= s_tdata[RAW_BITS +: TIME_BITS];
            lock_reg  <= s_tdata[RAW_BITS+TIME_BITS];
            diag_reg  <= s_tdata[RAW_BITS+TIME_BITS+1];
            force_reg <= s_tdata[RAW_BITS+TIME_BITS+2];
        end
    end

    // ------------------------------------------------------------------------
    // percent numerator and divider
    // ------------------------------------------------------------------------
    assign raw_ext = RAW_CMP_W'(raw_reg);
    assign under   = raw_ext < RAW_CMP_W'(lower_reg);
    assign over    = raw_ext > RAW_CMP_W'(upper_reg);
    assign err     = under || over;
    assign span    = upper_reg - lower_reg;
    // only meaningful when in range, where raw fits the limit width
    assign offset  = fthr_pkg::LIM_W'(raw_ext - RAW_CMP_W'(lower_reg));
    // 100 = 64 + 32 + 4
    assign numer   = (fthr_pkg::NUM_W'(offset) << 6) + (fthr_pkg::NUM_W'(offset) << 5)
                   + (fthr_pkg::NUM_W'(offset) << 2);
    assign div_start = (state_reg == ST_LOAD);

    fthr_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (numer),
        .denom (span),
        .stat  (div_stat)
    );

    // ------------------------------------------------------------------------
    // detection, reports and delayed switch
    // ------------------------------------------------------------------------
    always_comb
    begin
        // percent, with equal limits giving zero when raw is in range
        if (under)
        begin
            pct = '0;
        end
        else if (over)
        begin
            pct = fthr_pkg::PCT_FULL;
        end
        else if (span == '0)
        begin
            pct = '0;
        end
        else
        begin
            pct = div_stat.quot;
        end

        // limit lowered by the hysteresis while detected, floored at zero
        if (prev_det_reg)
        begin
            limit = (detect_pct_reg > hyst_reg) ? (detect_pct_reg - hyst_reg) : '0;
        end
        else
        begin
            limit = detect_pct_reg;
        end

        if (err)
        begin
            case (err_mode_reg)
                fthr_pkg::ERR_OFF:   det_base = 1'b0;
                fthr_pkg::ERR_ON:    det_base = 1'b1;
                fthr_pkg::ERR_SPLIT: det_base = !under;
                default:             det_base = prev_det_reg;
            endcase
        end
        else
        begin
            det_base = (pct >= limit);
        end

        // lock mode three ignores the lock and keeps the normal detection
        det = det_base;
        if (lock_reg)
        begin
            case (lock_mode_reg)
                fthr_pkg::LOCK_KEEP: det = prev_det_reg;
                fthr_pkg::LOCK_OFF:  det = 1'b0;
                fthr_pkg::LOCK_ON:   det = 1'b1;
                default:             det = det_base;
            endcase
        end

        raw_out = diag_reg ? raw_reg : '0;
        raw_rep = (prev_raw_reg != raw_out) || force_reg;

        step     = (step_cfg_reg == '0) ? 7'd1 : step_cfg_reg;
        pct_diff = (prev_pct_reg > pct) ? (prev_pct_reg - pct) : (pct - prev_pct_reg);
        pct_rep  = (pct_diff >= step) || force_reg || (prev_det_reg != det)
                 || ((prev_pct_reg != pct) && ((pct == '0) || (pct == fthr_pkg::PCT_FULL)));

        err_rep = (prev_err_reg != err) || force_reg;
        det_rep = (prev_det_reg != det) || force_reg;

        // elapsed time from the change mark after this transaction's update
        elapsed = det_rep ? '0 : (time_reg - chg_time_reg);
        sw = det;
        if (!det && (off_delay_reg != '0) && prev_dly_reg
            && (DLY_CMP_W'(elapsed) < DLY_CMP_W'(off_delay_reg)))
        begin
            sw = 1'b1;
        end
        dly_chg = (prev_dly_reg != sw) || force_reg;
        dly_rep = dly_chg && ((off_delay_reg != '0) || sw);
    end

    // ------------------------------------------------------------------------
    // sequencer, history and output register
    // ------------------------------------------------------------------------
    assign load_out = (state_reg == ST_FIN) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        prev_raw_next  = prev_raw_reg;
        prev_pct_next  = prev_pct_reg;
        prev_err_next  = prev_err_reg;
        prev_det_next  = prev_det_reg;
        chg_time_next  = chg_time_reg;
        prev_dly_next  = prev_dly_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (load_out)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    out_data_next  = OUT_W'({sw, dly_rep, det, det_rep, err, err_rep,
                                             pct, pct_rep,
                                             fthr_pkg::RAW_VAL_W'(raw_out), raw_rep});
                    if (raw_rep)
                    begin
                        prev_raw_next = raw_out;
                    end
                    if (pct_rep)
                    begin
                        prev_pct_next = pct;
                    end
                    if (err_rep)
                    begin
                        prev_err_next = err;
                    end
                    if (det_rep)
                    begin
                        prev_det_next = det;
                        chg_time_next = time_reg;
                    end
                    if (dly_chg)
                    begin
                        prev_dly_next = sw;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            prev_raw_reg  <= '0;
            prev_pct_reg  <= '0;
            prev_err_reg  <= 1'b0;
            prev_det_reg  <= 1'b0;
            chg_time_reg  <= '0;
            prev_dly_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            prev_raw_reg  <= prev_raw_next;
            prev_pct_reg  <= prev_pct_next;
            prev_err_reg  <= prev_err_next;
            prev_det_reg  <= prev_det_next;
            chg_time_reg  <= chg_time_next;
            prev_dly_reg  <= prev_dly_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    // the divider only finishes while the sequencer waits on it
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    // reported percent never exceeds full scale
    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[OUT_USED-7:OUT_USED-13] <= fthr_pkg::PCT_FULL))
        else $error("percent above full scale");

    // delayed switch is on whenever detection is on
    a_delay_covers_detect: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[28]) |-> m_tdata[30])
        else $error("delayed switch off while detected");

    // a new result is only loaded when the previous one has gone
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tdata == $past(m_tdata)) || !$past(load_out))
        else $error("pending result overwritten");

endmodule
